/* rtl/bsmd_pkg.sv */
// ----------------------------------------------------------------------------
// bsmd_pkg
// Shared widths, register indexes and item kind codes for the block
// sum/mean downsampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsmd_pkg;

	// fixed field widths
	localparam int VALUE_W    = 40;
	localparam int ROWS_W     = 11;
	localparam int COLS_W     = 16;
	localparam int FAC_W      = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// parameter defaults
	localparam int MAX_ROWS_DEF     = 1024;
	localparam int MAX_FACTOR_DEF   = 16;
	localparam int SAMPLE_WIDTH_DEF = 32;

	localparam int QUEUE_DEPTH = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd3;
	localparam int                   CFG_COUNT  = 4;

	// register reset values
	localparam logic [ROWS_W-1:0] ROWS_RST = 11'd1;
	localparam logic [COLS_W-1:0] COLS_RST = 16'd1;
	localparam logic [FAC_W-1:0]  FAC_RST  = 5'd1;
	localparam logic              MODE_RST = 1'b1;

	// how the back end has to finish a queued block
	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_ERR     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MISSING = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUM     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_MEAN    = 2'd3;

	typedef struct packed {
		logic              last_of_frame;
		logic [KIND_W-1:0] kind;
	} item_tag_t;

	localparam int TAG_W = $bits(item_tag_t);

endpackage

/* rtl/bsmd_if.sv */
// ----------------------------------------------------------------------------
// bsmd_if
// Valid/ready channels for raster samples in and block results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bsmd_in_if #(
	parameter int SAMPLE_WIDTH = bsmd_pkg::SAMPLE_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;
	logic                           sample_missing;

	modport source (output valid, output sample, output sample_missing, input ready);
	modport sink   (input valid, input sample, input sample_missing, output ready);
endinterface

interface bsmd_out_if;
	import bsmd_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] block_value;
	logic                      block_missing;
	logic                      last_of_frame;
	logic                      config_error;

	modport source (output valid, output block_value, output block_missing,
		output last_of_frame, output config_error, input ready);
	modport sink (input valid, input block_value, input block_missing,
		input last_of_frame, input config_error, output ready);
endinterface

/* rtl/bsmd_front.sv */
// ----------------------------------------------------------------------------
// bsmd_front
// Config registers, config check, raster position tracking and block
// accumulation against the per-strip partial-sum memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsmd_front #(
	parameter int MAX_ROWS     = bsmd_pkg::MAX_ROWS_DEF,
	parameter int MAX_FACTOR   = bsmd_pkg::MAX_FACTOR_DEF,
	parameter int SAMPLE_WIDTH = bsmd_pkg::SAMPLE_WIDTH_DEF,
	parameter int CNT_W        = 9,
	parameter int SUM_W        = 41,
	parameter int ITEM_W       = 53
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bsmd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bsmd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	bsmd_in_if.sink                            in_ch,
	output logic                               push,
	output logic [ITEM_W-1:0]                  push_data,
	input  logic                               full
);
	import bsmd_pkg::*;

	localparam int SLOT_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CHK_W  = $clog2(COLS_W);
	localparam int REM_W  = FAC_W + 1;

	logic [ROWS_W-1:0] rows_q;
	logic [COLS_W-1:0] cols_q;
	logic [FAC_W-1:0]  fac_q;
	logic              mean_q;

	logic              chk_busy_q;
	logic [CHK_W-1:0]  chk_cnt_q;
	logic [REM_W-1:0]  rem_r_q, rem_c_q;
	logic              cfg_ok_q;

	logic [SLOT_W-1:0] row_q;
	logic [SLOT_W-1:0] slot_q;
	logic [COLS_W-1:0] col_q;
	logic [FAC_W-1:0]  rin_q, cin_q;

	logic signed [SUM_W-1:0] col_sum_q;
	logic [CNT_W-1:0]        col_cnt_q;
	logic [CNT_W+SUM_W-1:0]  rd_q;
	logic [CNT_W+SUM_W-1:0]  mem [MAX_ROWS];

	logic                    restart, accept, static_ok;
	logic [CHK_W-1:0]        chk_idx;
	logic [COLS_W-1:0]       rows_ext;
	logic [REM_W-1:0]        rem_r_n, rem_c_n;
	logic signed [SUM_W-1:0] s_ext, s_val, col_sum_n, blk_sum, rd_sum;
	logic [CNT_W-1:0]        col_cnt_n, blk_cnt, rd_cnt;
	logic                    last_r, last_c, last_row, last_col, blk_done;
	logic                    wr_en, rd_en;
	item_tag_t               tag;

	// one restoring remainder step: bring in the next dividend bit
	function automatic logic [REM_W-1:0] rem_step(input logic [REM_W-1:0] rem,
		input logic b, input logic [FAC_W-1:0] f);
		logic [REM_W-1:0] t;
		t = {rem[REM_W-2:0], b};
		if (t >= {1'b0, f}) begin
			t = t - {1'b0, f};
		end
		return t;
	endfunction

	assign restart  = cfg_we && (32'(cfg_index) < CFG_COUNT);
	assign rows_ext = COLS_W'(rows_q);
	assign chk_idx  = CHK_W'(COLS_W - 1) - chk_cnt_q;
	assign rem_r_n  = rem_step(rem_r_q, rows_ext[chk_idx], fac_q);
	assign rem_c_n  = rem_step(rem_c_q, cols_q[chk_idx], fac_q);

	assign static_ok = (fac_q != '0) && (32'(fac_q) <= MAX_FACTOR) &&
		(rows_q != '0) && (32'(rows_q) <= MAX_ROWS) && (cols_q != '0);

	assign in_ch.ready = !chk_busy_q && !full;
	assign accept      = in_ch.valid && in_ch.ready;

	// configuration registers and divisibility check (one bit per cycle)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= ROWS_RST;
			cols_q     <= COLS_RST;
			fac_q      <= FAC_RST;
			mean_q     <= MODE_RST;
			chk_busy_q <= 1'b0;
			chk_cnt_q  <= '0;
			rem_r_q    <= '0;
			rem_c_q    <= '0;
			cfg_ok_q   <= 1'b1;
		end else if (restart) begin
			case (cfg_index)
				CFG_ROWS:   rows_q <= cfg_wdata[ROWS_W-1:0];
				CFG_COLS:   cols_q <= cfg_wdata[COLS_W-1:0];
				CFG_FACTOR: fac_q  <= cfg_wdata[FAC_W-1:0];
				CFG_MODE:   mean_q <= cfg_wdata[0];
				default:    ;
			endcase
			chk_busy_q <= 1'b1;
			chk_cnt_q  <= '0;
			rem_r_q    <= '0;
			rem_c_q    <= '0;
		end else if (chk_busy_q) begin
			rem_r_q   <= rem_r_n;
			rem_c_q   <= rem_c_n;
			chk_cnt_q <= chk_cnt_q + 1'b1;
			if (chk_cnt_q == CHK_W'(COLS_W - 1)) begin
				chk_busy_q <= 1'b0;
				cfg_ok_q   <= static_ok && (rem_r_n == '0) && (rem_c_n == '0);
			end
		end
	end

	// block accumulation
	assign s_ext     = SUM_W'($signed(in_ch.sample[SAMPLE_WIDTH-1:0]));
	assign s_val     = in_ch.sample_missing ? '0 : s_ext;
	assign rd_sum    = rd_q[SUM_W-1:0];
	assign rd_cnt    = rd_q[CNT_W+SUM_W-1:SUM_W];
	assign col_sum_n = ((rin_q == '0) ? '0 : col_sum_q) + s_val;
	assign col_cnt_n = ((rin_q == '0) ? '0 : col_cnt_q) + CNT_W'(!in_ch.sample_missing);
	// first column of a block starts fresh, later ones add the strip memory
	assign blk_sum   = ((cin_q == '0) ? '0 : rd_sum) + col_sum_n;
	assign blk_cnt   = ((cin_q == '0) ? '0 : rd_cnt) + col_cnt_n;

	assign last_r   = (rin_q == fac_q - 1'b1);
	assign last_c   = (cin_q == fac_q - 1'b1);
	assign last_row = (32'(row_q) == 32'(rows_q) - 1);
	assign last_col = (col_q == cols_q - 1'b1);
	assign blk_done = last_r && last_c;

	assign rd_en = accept && cfg_ok_q && (rin_q == '0);
	assign wr_en = accept && cfg_ok_q && last_r && !last_c;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot_q] <= {blk_cnt, blk_sum};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cfg_ok_q) begin
			col_sum_q <= col_sum_n;
			col_cnt_q <= col_cnt_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			slot_q <= '0;
			col_q  <= '0;
			rin_q  <= '0;
			cin_q  <= '0;
		end else if (restart) begin
			row_q  <= '0;
			slot_q <= '0;
			col_q  <= '0;
			rin_q  <= '0;
			cin_q  <= '0;
		end else if (accept && cfg_ok_q) begin
			if (last_row) begin
				row_q  <= '0;
				slot_q <= '0;
				rin_q  <= '0;
				col_q  <= last_col ? '0 : col_q + 1'b1;
				cin_q  <= (last_c || last_col) ? '0 : cin_q + 1'b1;
			end else begin
				row_q  <= row_q + 1'b1;
				rin_q  <= last_r ? '0 : rin_q + 1'b1;
				slot_q <= last_r ? slot_q + 1'b1 : slot_q;
			end
		end
	end

	// classify the finished block for the back end
	always_comb begin
		tag.last_of_frame = 1'b0;
		if (!cfg_ok_q) begin
			tag.kind = KIND_ERR;
		end else if (blk_cnt == '0) begin
			tag.kind = KIND_MISSING;
		end else if (mean_q) begin
			tag.kind = KIND_MEAN;
		end else begin
			tag.kind = KIND_SUM;
		end
		if (cfg_ok_q) begin
			tag.last_of_frame = last_row && last_col;
		end
	end

	assign push      = accept && (!cfg_ok_q || blk_done);
	assign push_data = cfg_ok_q ? {tag, blk_cnt, blk_sum} : {tag, {(CNT_W + SUM_W){1'b0}}};

endmodule

/* rtl/bsmd_fifo.sv */
// ----------------------------------------------------------------------------
// bsmd_fifo
// Short register queue between the accumulating front and the dividing
// back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsmd_fifo #(
	parameter int WIDTH = 53,
	parameter int DEPTH = bsmd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

/* rtl/bsmd_back.sv */
// ----------------------------------------------------------------------------
// bsmd_back
// Finishes queued blocks: bit-serial signed division for mean mode and the
// result output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsmd_back #(
	parameter int CNT_W  = 9,
	parameter int SUM_W  = 41,
	parameter int ITEM_W = 53
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  logic [ITEM_W-1:0] pop_data,
	output logic              pop,
	bsmd_out_if.source        out_ch
);
	import bsmd_pkg::*;

	localparam int DCNT_W = $clog2(SUM_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]              state_q;
	logic [SUM_W-1:0]        quo_q;
	logic [CNT_W-1:0]        rem_q, div_q;
	logic                    neg_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic signed [VALUE_W-1:0] val_q;
	logic                    miss_q, lof_q, err_q;

	item_tag_t               tag;
	logic signed [SUM_W-1:0] in_sum;
	logic [CNT_W-1:0]        in_cnt;
	logic [SUM_W-1:0]        in_mag;
	logic [CNT_W:0]          rem_sh;
	logic                    qbit;
	logic [CNT_W-1:0]        rem_n;
	logic [SUM_W-1:0]        quo_n;
	logic signed [SUM_W-1:0] div_res;

	assign tag    = pop_data[ITEM_W-1:CNT_W+SUM_W];
	assign in_cnt = pop_data[CNT_W+SUM_W-1:SUM_W];
	assign in_sum = pop_data[SUM_W-1:0];
	assign in_mag = in_sum[SUM_W-1] ? ~in_sum + 1'b1 : in_sum;

	// restoring step on the magnitude, quotient shifts in from the right
	assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
	assign qbit    = (rem_sh >= {1'b0, div_q});
	assign rem_n   = qbit ? CNT_W'(rem_sh - {1'b0, div_q}) : rem_sh[CNT_W-1:0];
	assign quo_n   = {quo_q[SUM_W-2:0], qbit};
	assign div_res = neg_q ? ~quo_n + 1'b1 : quo_n;

	assign pop = (state_q == ST_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						state_q <= (tag.kind == KIND_MEAN) ? ST_DIV : ST_OUT;
					end
				end
				ST_DIV: begin
					if (dcnt_q == DCNT_W'(SUM_W - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			lof_q  <= tag.last_of_frame;
			miss_q <= (tag.kind == KIND_MISSING);
			err_q  <= (tag.kind == KIND_ERR);
			val_q  <= (tag.kind == KIND_SUM) ? VALUE_W'(in_sum) : '0;
			quo_q  <= in_mag;
			rem_q  <= '0;
			div_q  <= in_cnt;
			neg_q  <= in_sum[SUM_W-1];
			dcnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			quo_q  <= quo_n;
			rem_q  <= rem_n;
			dcnt_q <= dcnt_q + 1'b1;
			if (dcnt_q == DCNT_W'(SUM_W - 1)) begin
				val_q <= VALUE_W'(div_res);
			end
		end
	end

	assign out_ch.valid         = (state_q == ST_OUT);
	assign out_ch.block_value   = val_q;
	assign out_ch.block_missing = miss_q;
	assign out_ch.last_of_frame = lof_q;
	assign out_ch.config_error  = err_q;

endmodule

/* rtl/block_sum_mean_downsample_unit.sv */
// Result path: a block's last sample goes into the queue; the back end pops it
// and, in mean mode, divides bit-serially over SUM_W = SAMPLE_WIDTH + count bits.
// Throughput: one sample per cycle unless the queue is full or the config check
// runs; the back end finishes a result before popping the next; a 4-entry queue
// absorbs. A config write holds off samples during the divisibility check.
// Reset clears control state only; the strip memory is rewritten before use.
// ----------------------------------------------------------------------------
// block_sum_mean_downsample_unit
// Block sum / block mean downsampler for a column-major raster with missing
// samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_sum_mean_downsample_unit #(
	parameter int MAX_ROWS     = bsmd_pkg::MAX_ROWS_DEF,
	parameter int MAX_FACTOR   = bsmd_pkg::MAX_FACTOR_DEF,
	parameter int SAMPLE_WIDTH = bsmd_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bsmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsmd_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bsmd_in_if.sink                         in_ch,
	bsmd_out_if.source                      out_ch
);
	import bsmd_pkg::*;

	localparam int CNT_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
	localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;
	localparam int ITEM_W = TAG_W + CNT_W + SUM_W;

	logic              push, pop, full, empty;
	logic [ITEM_W-1:0] push_data, pop_data;

	bsmd_front #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_FACTOR  (MAX_FACTOR),
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W),
		.ITEM_W      (ITEM_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.push     (push),
		.push_data(push_data),
		.full     (full)
	);

	bsmd_fifo #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (empty)
	);

	bsmd_back #(
		.CNT_W (CNT_W),
		.SUM_W (SUM_W),
		.ITEM_W(ITEM_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.pop_data(pop_data),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

/* rtl/bsmd_checker.sv */
// ----------------------------------------------------------------------------
// bsmd_checker
// Port-level checks on the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsmd_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cfg_we,
	input logic [bsmd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [bsmd_pkg::VALUE_W-1:0]    out_value,
	input logic                            out_missing,
	input logic                            out_lof,
	input logic                            out_err
);
	import bsmd_pkg::*;

	// a stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_missing) &&
			$stable(out_lof) && $stable(out_err))
		else $error("result beat changed while stalled");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_err |-> (out_value == '0) && !out_missing && !out_lof)
		else $error("config error beat carries data");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_missing |-> (out_value == '0) && !out_err)
		else $error("missing block with nonzero value");

	// a register write starts the config check, which holds off samples
	a_cfg_holdoff: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (32'(cfg_index) < CFG_COUNT) |=> !in_ready)
		else $error("samples taken right after a config write");

endmodule

bind block_sum_mean_downsample_unit bsmd_checker u_bsmd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_value  (out_ch.block_value),
	.out_missing(out_ch.block_missing),
	.out_lof    (out_ch.last_of_frame),
	.out_err    (out_ch.config_error)
);
